[design/epcal_pkg.sv]
package epcal_pkg;

	localparam int SECONDS_WIDTH_DEF = 32;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;
	localparam int TOD_W      = 17;
	localparam int SPAN_W     = 25;
	localparam int PC_W       = 3;

	localparam int DAYS_PER_YEAR = 365;

	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
	localparam logic [TOD_W-1:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;
	localparam logic [SPAN_W-1:0] SECS_PER_YEAR      = SPAN_W'(DAYS_PER_YEAR * SECS_PER_DAY);
	localparam logic [SPAN_W-1:0] SECS_PER_LEAP_YEAR =
		SPAN_W'((DAYS_PER_YEAR + 1) * SECS_PER_DAY);

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_YEAR,
		OP_MONTH,
		OP_DAY,
		OP_HOUR,
		OP_MIN,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [PC_W-1:0] nxt;
		logic [PC_W-1:0] jmp;
	} ucode_t;

	localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] ST_YEAR  = 3'd1;
	localparam logic [PC_W-1:0] ST_MONTH = 3'd2;
	localparam logic [PC_W-1:0] ST_DAY   = 3'd3;
	localparam logic [PC_W-1:0] ST_HOUR  = 3'd4;
	localparam logic [PC_W-1:0] ST_MIN   = 3'd5;
	localparam logic [PC_W-1:0] ST_DONE  = 3'd6;

	// nxt is taken when the step condition holds, jmp otherwise
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			ST_IDLE:  w = '{OP_IDLE,  ST_YEAR,  ST_IDLE};
			ST_YEAR:  w = '{OP_YEAR,  ST_MONTH, ST_YEAR};
			ST_MONTH: w = '{OP_MONTH, ST_DAY,   ST_MONTH};
			ST_DAY:   w = '{OP_DAY,   ST_HOUR,  ST_DAY};
			ST_HOUR:  w = '{OP_HOUR,  ST_MIN,   ST_HOUR};
			ST_MIN:   w = '{OP_MIN,   ST_DONE,  ST_MIN};
			ST_DONE:  w = '{OP_DONE,  ST_IDLE,  ST_DONE};
			default:  w = '{OP_IDLE,  ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

	// length of the month in seconds
	function automatic logic [SPAN_W-1:0] month_secs(input logic [3:0] month, input logic leap);
		logic [SPAN_W-1:0] s;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = SPAN_W'(31 * SECS_PER_DAY);
			4'd4, 4'd6, 4'd9, 4'd11:                    s = SPAN_W'(30 * SECS_PER_DAY);
			4'd2: s = leap ? SPAN_W'(29 * SECS_PER_DAY) : SPAN_W'(28 * SECS_PER_DAY);
			default:                                    s = SPAN_W'(31 * SECS_PER_DAY);
		endcase
		return s;
	endfunction

	// month length in days, mod 7
	function automatic logic [1:0] month_wd_step(input logic [3:0] month, input logic leap);
		logic [1:0] d;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 2'd3;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 2'd2;
			4'd2:                                       d = leap ? 2'd1 : 2'd0;
			default:                                    d = 2'd3;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [1:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {2'b00, b};
		return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
	endfunction

endpackage

[design/epoch_seconds_to_calendar_date_unit.sv]
// Converts a count of seconds since 1970-01-01 00:00 UTC into a Gregorian date
// and time of day, plus a weekday index (0 is Thursday, the epoch day).
// Input channel s_*: one beat per timestamp; only the low SECONDS_WIDTH bits count.
// Output channel m_*: one beat per input beat, in the same order.
// A small microcode table steps a shared compare-and-subtract datapath over the
// remaining seconds, taking off a year, month, day, hour or minute at a time;
// each of those five loops closes once the remaining seconds fall below its unit.
// At the default width the year loop takes the most steps.
// One item is in flight at a time; s_tready is high only while the sequencer
// sits in its idle step, in the cycle after a result is loaded. The finished result
// sits in an output register, so the next beat is accepted while the previous
// result waits on m_tready.
// If the receiver stalls with a result still held, the sequencer waits in its
// last step until the register frees up; nothing is dropped.
// Reset (arst_n low) returns the sequencer to idle and clears m_tvalid.
module epoch_seconds_to_calendar_date_unit
	import epcal_pkg::*;
#(
	parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] epoch_seconds
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int SW = SECONDS_WIDTH;

	logic [PC_W-1:0]  pc_q;
	logic             m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [SW-1:0]    left_q;
	logic [11:0]      year_q;
	logic [1:0]       mod4_q;
	logic [6:0]       mod100_q;
	logic [8:0]       mod400_q;
	logic [3:0]       month_q;
	logic [4:0]       day_q;
	logic [4:0]       hour_q;
	logic [5:0]       min_q;
	logic [2:0]       wd_q;

	ucode_t           uw;
	logic             go;
	logic [SW+IN_DATA_W-1:0] secs_ext;
	logic [SW-1:0]    secs_in;
	logic             leap;
	logic [SPAN_W-1:0] ylen;
	logic [SPAN_W-1:0] mlen;
	logic [SW-1:0]    span;
	logic [1:0]       wd_step;
	logic             left_lt;

	assign secs_ext = {{SW{1'b0}}, s_tdata};
	assign secs_in  = secs_ext[SW-1:0];

	assign uw = ucode_rom(pc_q);

	assign leap = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (mod4_q == 2'd0));
	assign ylen = leap ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
	assign mlen = month_secs(month_q, leap);

	// the control word picks the unit taken off the remaining seconds
	always_comb begin
		unique case (uw.op)
			OP_YEAR: begin
				span    = SW'(ylen);
				wd_step = leap ? 2'd2 : 2'd1;
			end
			OP_MONTH: begin
				span    = SW'(mlen);
				wd_step = month_wd_step(month_q, leap);
			end
			OP_DAY: begin
				span    = SW'(SECS_PER_DAY);
				wd_step = 2'd1;
			end
			OP_HOUR: begin
				span    = SW'(SECS_PER_HOUR);
				wd_step = 2'd0;
			end
			OP_MIN: begin
				span    = SW'(SECS_PER_MIN);
				wd_step = 2'd0;
			end
			default: begin
				span    = '0;
				wd_step = 2'd0;
			end
		endcase
	end

	assign left_lt = (left_q < span);

	always_comb begin
		unique case (uw.op)
			OP_IDLE:  go = s_tvalid;
			OP_YEAR:  go = left_lt;
			OP_MONTH: go = left_lt;
			OP_DAY:   go = left_lt;
			OP_HOUR:  go = left_lt;
			OP_MIN:   go = left_lt;
			OP_DONE:  go = !m_tvalid_q || m_tready;
			default:  go = 1'b1;
		endcase
	end

	assign s_tready = (uw.op == OP_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= go ? uw.nxt : uw.jmp;
			if (uw.op == OP_DONE && go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_IDLE: begin
				if (s_tvalid) begin
					left_q   <= secs_in;
					year_q   <= EPOCH_YEAR;
					mod4_q   <= EPOCH_MOD4;
					mod100_q <= EPOCH_MOD100;
					mod400_q <= EPOCH_MOD400;
					month_q  <= 4'd1;
					day_q    <= 5'd0;
					hour_q   <= 5'd0;
					min_q    <= 6'd0;
					wd_q     <= 3'd0;
				end
			end
			OP_YEAR: begin
				if (!go) begin
					left_q   <= left_q - span;
					year_q   <= year_q + 12'd1;
					mod4_q   <= mod4_q + 2'd1;
					mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
					wd_q     <= add_mod7(wd_q, wd_step);
				end
			end
			OP_MONTH: begin
				if (!go) begin
					left_q  <= left_q - span;
					month_q <= month_q + 4'd1;
					wd_q    <= add_mod7(wd_q, wd_step);
				end
			end
			OP_DAY: begin
				if (!go) begin
					left_q <= left_q - span;
					day_q  <= day_q + 5'd1;
					wd_q   <= add_mod7(wd_q, wd_step);
				end
			end
			OP_HOUR: begin
				if (!go) begin
					left_q <= left_q - span;
					hour_q <= hour_q + 5'd1;
				end
			end
			OP_MIN: begin
				if (!go) begin
					left_q <= left_q - span;
					min_q  <= min_q + 6'd1;
				end
			end
			OP_DONE: begin
				// what is left of the seconds is below one minute here
				if (go) begin
					m_tdata_q <= {7'd0, wd_q, left_q[5:0], min_q, hour_q,
						day_q + 5'd1, month_q, year_q};
				end
			end
			default: begin
			end
		endcase
	end

	// a beat taken at idle starts the year loop
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (pc_q == ST_YEAR))
		else $error("sequencer did not start after accept");

	// leaving the last step always fills the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DONE && go) |=> m_tvalid)
		else $error("result lost at end of program");

	// month stays in 1 to 12 and day of month is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12
			&& m_tdata[20:16] != 5'd0))
		else $error("month or day out of range");

	// time of day and weekday fields stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:21] < 5'd24 && m_tdata[31:26] < 6'd60
			&& m_tdata[37:32] < 6'd60 && m_tdata[40:38] < 3'd7))
		else $error("time of day or weekday out of range");

endmodule
